/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/plstore_pkg.sv */
// ----------------------------------------------------------------------------
// plstore_pkg
// Types, codes and sizing constants of the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

package plstore_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int CAPACITY_MAX     = 1024;

    // Width of the position bus handed to every cell.
    localparam int POS_BUS_W = $clog2(CAPACITY_MAX);
    // Width used for count and position comparisons.
    localparam int CNT_W     = $clog2(CAPACITY_MAX + 1);

    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int ACT_W     = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         entry_count;
        logic [1:0]               error_code;
    } rsp_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                     insert_en;
        logic                     remove_en;
        logic                     lookup_en;
        logic [POS_BUS_W-1:0]     pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/plstore_stream_if.sv */
// ----------------------------------------------------------------------------
// plstore_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface plstore_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/plstore_cell.sv */
// ----------------------------------------------------------------------------
// plstore_cell
// One list slot: holds an entry and shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
`default_nettype none

module plstore_cell
    import plstore_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0]      data,
    output logic signed [DATA_W-1:0]      hit_data
);

    localparam logic [POS_BUS_W-1:0] IDX = POS_BUS_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     match;
    logic                     above;

    assign match = (ctrl.pos == IDX);
    assign above = (IDX > ctrl.pos);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.insert_en)
        begin
            if (above)
                data_next = left_data;
            else if (match)
                data_next = ctrl.value;
        end
        else if (ctrl.remove_en && (match || above))
        begin
            data_next = right_data;
        end
    end

    // Entry contents need no reset: slots at or above the count are never read.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (ctrl.lookup_en && match) ? data_reg : '0;

endmodule

`default_nettype wire

/* sv/positional_list_store_core.sv */
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of signed 32-bit values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                               Handshake
//   req      in         action, position, value               valid/ready
//   rsp      out        data_out, entry_count, error_code     valid/ready
//
// Every request transaction completes at the accepting edge: all cells update in
// parallel there and the result is registered for the next cycle.
// A request is taken whenever the result register is empty or is being
// drained in the same cycle, so a stalled rsp channel stalls req as well.
// Reset clears the count and the result valid flag; cell contents stay
// undefined until written and need no clearing pass.
//
`default_nettype none

module positional_list_store_core
    import plstore_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    plstore_stream_if.sink     req,
    plstore_stream_if.source   rsp
);

    // The count must be able to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_data_reg;

    logic                     accept;
    logic [CNT_W-1:0]         pos_w;
    logic [CNT_W-1:0]         cnt_w;
    err_t                     err;
    logic                     do_insert;
    logic                     do_remove;
    logic                     do_lookup;
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] hit_or;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_hit  [CAPACITY];

    // The result register frees up when it is empty or being taken this cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_w = CNT_W'(req.payload.position);
    assign cnt_w = CNT_W'(count_reg);

    // Decode the request and check it against the current count. An insert
    // tests the position before fullness; remove and read require the
    // position to name a held entry; an unknown action is a range error.
    always_comb
    begin
        err       = ERR_RANGE;
        do_insert = 1'b0;
        do_remove = 1'b0;
        do_lookup = 1'b0;
        case (req.payload.action)
            ACT_INSERT:
            begin
                if (pos_w > cnt_w)
                    err = ERR_RANGE;
                else if (cnt_w == CNT_W'(CAPACITY))
                    err = ERR_FULL;
                else
                begin
                    err       = ERR_NONE;
                    do_insert = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (pos_w < cnt_w)
                begin
                    err       = ERR_NONE;
                    do_remove = 1'b1;
                    do_lookup = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (pos_w < cnt_w)
                begin
                    err       = ERR_NONE;
                    do_lookup = 1'b1;
                end
            end
            default:
            begin
                err = ERR_RANGE;
            end
        endcase
    end

    // Cells only move on an accepted transaction.
    assign ctrl.insert_en = accept && do_insert;
    assign ctrl.remove_en = accept && do_remove;
    assign ctrl.lookup_en = do_lookup;
    assign ctrl.pos       = POS_BUS_W'(req.payload.position);
    assign ctrl.value     = req.payload.value;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert_en)
            count_next = count_reg + CW'(1);
        else if (ctrl.remove_en)
            count_next = count_reg - CW'(1);
    end

    // The chain: each cell sees its lower neighbor for an insert shift and
    // its upper neighbor for a remove shift. The ends are tied off, since the
    // bottom cell never shifts up and the top cell only shifts in past data.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_in;
            logic signed [DATA_W-1:0] right_in;

            if (gi == 0)
            begin : g_bottom
                assign left_in = '0;
            end
            else
            begin : g_lower
                assign left_in = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_top
                assign right_in = '0;
            end
            else
            begin : g_upper
                assign right_in = cell_data[gi+1];
            end

            plstore_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[gi]),
                .hit_data   (cell_hit[gi])
            );
        end
    endgenerate

    // At most one cell answers a lookup, so the answers are OR-combined.
    // Without a lookup every cell answers zero, which gives the zero data of
    // inserts and errors.
    always_comb
    begin
        hit_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            hit_or = hit_or | cell_hit[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload; the count is reported masked to the port width.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg.data_out    <= hit_or;
            rsp_data_reg.entry_count <= POS_W'(count_next);
            rsp_data_reg.error_code  <= err;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule

`default_nettype wire

/* sv/plstore_checker.sv */
// ----------------------------------------------------------------------------
// plstore_checker
// Port-level assertions for the positional list store, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module plstore_checker
    import plstore_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     rsp_valid,
    input wire logic                     rsp_ready,
    input wire logic signed [DATA_W-1:0] data_out,
    input wire logic [POS_W-1:0]         entry_count,
    input wire logic [1:0]               error_code
);

    localparam logic [CNT_W-1:0] CAP_W    = CNT_W'(CAPACITY);
    // The full count as it shows on the masked count port.
    localparam logic [POS_W-1:0] CAP_PORT = POS_W'(CAPACITY);

    logic [CNT_W-1:0] count_w;
    logic             rsp_error;
    logic             rsp_full;

    assign count_w   = CNT_W'(entry_count);
    assign rsp_error = (error_code != ERR_NONE);
    assign rsp_full  = (error_code == ERR_FULL);

    // A pending result stays offered until it is taken.
    `ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)

    // A failed request never returns data.
    `ASSERT_IMPLIES(a_err_zero_data, clk, rst_n, rsp_valid && rsp_error, data_out == '0)

    // The reported count never exceeds the capacity.
    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, rsp_valid, count_w <= CAP_W)

    // A full error only happens with the list at capacity.
    `ASSERT_IMPLIES(a_full_at_cap, clk, rst_n, rsp_valid && rsp_full, entry_count == CAP_PORT)

endmodule

bind positional_list_store_core plstore_checker #(
    .CAPACITY (CAPACITY)
) u_plstore_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .data_out    (rsp.payload.data_out),
    .entry_count (rsp.payload.entry_count),
    .error_code  (rsp.payload.error_code)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list store core: a shadow copy of
// the list predicts each result from the accepted requests, and both the
// request and result channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb
    import plstore_pkg::*;
;

    localparam int LIST_CAPACITY  = 64;
    localparam int RANDOM_ITEMS   = 900;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Action code 3 has no meaning in the block; it must come back as a
    // range error with the list untouched.
    localparam logic [ACT_W-1:0] ACT_UNDEFINED = 2'd3;

    // Bias of a stretch of random requests.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } mix_t;

    // ------------------------------------------------------------------------
    // Shadow copy of the list. note_request applies an accepted request to
    // the copy and queues the result it must produce; check_result compares
    // a returned result with the oldest queued one.
    // ------------------------------------------------------------------------
    class list_mirror;
        logic signed [DATA_W-1:0] slots [LIST_CAPACITY];
        int unsigned              count;
        rsp_t                     awaited_results [$];
        int unsigned              mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function void note_request(req_t r);
            rsp_t        want;
            int unsigned pos;
            pos              = 32'(r.position);
            want.data_out    = '0;
            want.error_code  = ERR_NONE;
            case (r.action)
                ACT_INSERT:
                begin
                    // The position is checked before fullness.
                    if (pos > count)
                        want.error_code = ERR_RANGE;
                    else if (count >= LIST_CAPACITY)
                        want.error_code = ERR_FULL;
                    else
                    begin
                        for (int i = count; i > pos; i--)
                            slots[i] = slots[i-1];
                        slots[pos] = r.value;
                        count++;
                    end
                end
                ACT_REMOVE:
                begin
                    if (pos >= count)
                        want.error_code = ERR_RANGE;
                    else
                    begin
                        want.data_out = slots[pos];
                        for (int i = pos; i + 1 < count; i++)
                            slots[i] = slots[i+1];
                        count--;
                    end
                end
                ACT_READ:
                begin
                    if (pos >= count)
                        want.error_code = ERR_RANGE;
                    else
                        want.data_out = slots[pos];
                end
                default:
                    want.error_code = ERR_RANGE;
            endcase
            want.entry_count = count[POS_W-1:0];
            awaited_results.push_back(want);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: stray result: data %0d count %0d err %0d",
                             $realtime, got.data_out, got.entry_count, got.error_code);
                return;
            end
            want = awaited_results.pop_front();
            if (got.data_out !== want.data_out || got.entry_count !== want.entry_count ||
                got.error_code !== want.error_code)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected data %0d count %0d err %0d, %s %0d %0d %0d",
                             $realtime, want.data_out, want.entry_count, want.error_code,
                             "got data/count/err", got.data_out, got.entry_count,
                             got.error_code);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    plstore_stream_if #(.payload_t(req_t)) req_if ();
    plstore_stream_if #(.payload_t(rsp_t)) rsp_if ();

    positional_list_store_core #(
        .CAPACITY (LIST_CAPACITY)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_mirror  shadow      = new();
    int unsigned idle_cycles = 0;

    // When set, the sender or receiver stops idling for a while.
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    // Asks the receiver for one long hold-off.
    bit hold_rx_now = 1'b0;

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge; inputs only move
    // at the falling edge, so the sampled values are settled. An accepted
    // request updates the shadow list before the next request is built, so
    // the generator always sees the true count. The watchdog counts edges
    // with no transaction on either channel.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (req_if.valid && req_if.ready)
            begin
                shadow.note_request(req_if.payload);
                idle_cycles = 0;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                shadow.check_result(rsp_if.payload);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Drops ready for random gaps and, on request, for one
    // long hold-off counted here; during that hold-off the sender keeps
    // offering requests, so the single result register fills and the block
    // must stall its request channel.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin : receiver
            int stall;
            @(negedge clk);
            if (hold_rx_now)
            begin
                hold_rx_now  = 1'b0;
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = pick_gap(rx_quiet);
            if (stall > 0)
            begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    // Offers one request after a random gap and holds it until the block
    // takes it. Called and returns at a falling edge.
    task automatic send_request(req_t r);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid   = 1'b1;
        req_if.payload = r;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic send_fields(logic [ACT_W-1:0] action, logic [POS_W-1:0] position,
                               logic signed [DATA_W-1:0] value);
        req_t r;
        r.action   = action;
        r.position = position;
        r.value    = value;
        send_request(r);
    endtask

    // Builds one random request from the current count. Most positions are
    // in range so the list actually grows and shrinks; the rest hit the
    // ends, the exact count, or anywhere in the 7-bit field.
    function automatic req_t make_request(mix_t mix);
        req_t        r;
        int          roll;
        int          insert_pct;
        int          remove_pct;
        int unsigned cnt;
        cnt = shadow.count;
        case (mix)
            MIX_GROW:   begin insert_pct = 80; remove_pct = 5;  end
            MIX_SHRINK: begin insert_pct = 10; remove_pct = 75; end
            default:    begin insert_pct = 40; remove_pct = 35; end
        endcase

        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.action = ACT_UNDEFINED;
        else if (roll < 3 + insert_pct)
            r.action = ACT_INSERT;
        else if (roll < 3 + insert_pct + remove_pct)
            r.action = ACT_REMOVE;
        else
            r.action = ACT_READ;

        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            if (r.action == ACT_INSERT)
                r.position = POS_W'($urandom_range(0, cnt));
            else
                r.position = (cnt > 0) ? POS_W'($urandom_range(0, cnt - 1)) : '0;
        end
        else if (roll < 88)
            r.position = POS_W'(cnt);
        else if (roll < 93)
            r.position = '0;
        else
            r.position = POS_W'($urandom_range(0, 127));

        roll = $urandom_range(0, 99);
        if (roll < 85)
            r.value = $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0:       r.value = 32'sh8000_0000;
                1:       r.value = 32'sh7FFF_FFFF;
                2:       r.value = 32'sh0000_0000;
                default: r.value = -32'sd1;
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, a directed walk over the corner cases, then
    // random stretches that each lean at random toward filling the list, draining
    // it or neither, then a drain and the verdict.
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int   issued;
        int   run_len;
        mix_t mix;

        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Requests on the empty list, an insert past the end, and the
        // undefined action code.
        send_fields(ACT_READ,      7'd0,   32'sd0);
        send_fields(ACT_REMOVE,    7'd0,   32'sd0);
        send_fields(ACT_INSERT,    7'd1,   32'sd5);
        send_fields(ACT_UNDEFINED, 7'd0,   32'sd0);
        // Build [-1, max, 0, 0x55555555, min] through front, back and middle
        // inserts, using the value extremes.
        send_fields(ACT_INSERT,    7'd0,   32'sh7FFF_FFFF);
        send_fields(ACT_INSERT,    7'd1,   32'sh8000_0000);
        send_fields(ACT_INSERT,    7'd1,   32'sh0000_0000);
        send_fields(ACT_INSERT,    7'd0,   -32'sd1);
        send_fields(ACT_INSERT,    7'd3,   32'sh5555_5555);
        // Insert beyond the count and at the largest position value.
        send_fields(ACT_INSERT,    7'd6,   32'sd1);
        send_fields(ACT_INSERT,    7'd127, 32'shAAAA_AAAA);
        // Reads at the front, the back, just past the back and far out.
        send_fields(ACT_READ,      7'd0,   32'sd0);
        send_fields(ACT_READ,      7'd4,   32'sd0);
        send_fields(ACT_READ,      7'd5,   32'sd0);
        send_fields(ACT_READ,      7'd127, -32'sd1);
        // Removes from the middle, the front and the back, then past the end.
        send_fields(ACT_REMOVE,    7'd2,   32'sd0);
        send_fields(ACT_REMOVE,    7'd0,   32'sd0);
        send_fields(ACT_REMOVE,    7'd2,   32'sd0);
        send_fields(ACT_REMOVE,    7'd2,   32'sd0);
        send_fields(ACT_UNDEFINED, 7'd127, -32'sd1);
        // Empty it again and read the empty list.
        send_fields(ACT_REMOVE,    7'd1,   32'sd0);
        send_fields(ACT_REMOVE,    7'd0,   32'sd0);
        send_fields(ACT_READ,      7'd0,   32'sd0);

        // First random stretch fills the list well past capacity with the
        // sender never idling, while the receiver holds off for a long time.
        issued      = 0;
        tx_quiet    = 1'b1;
        rx_quiet    = 1'b0;
        hold_rx_now = 1'b1;
        repeat (150)
        begin
            send_request(make_request(MIX_GROW));
            issued++;
        end

        while (issued < RANDOM_ITEMS)
        begin
            // Pick a filling, draining or balanced stretch at random; each
            // stretch has its own idling pattern.
            case ($urandom_range(0, 2))
                0:       mix = MIX_GROW;
                1:       mix = MIX_SHRINK;
                default: mix = MIX_BALANCED;
            endcase
            run_len  = $urandom_range(40, 150);
            // The last stretch stops at the planned number of requests.
            if (run_len > RANDOM_ITEMS - issued)
                run_len = RANDOM_ITEMS - issued;
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            // One more long hold-off about halfway through.
            if (issued < RANDOM_ITEMS / 2 && issued + run_len >= RANDOM_ITEMS / 2)
                hold_rx_now = 1'b1;
            repeat (run_len)
            begin
                send_request(make_request(mix));
                issued++;
            end
        end

        req_if.valid = 1'b0;

        // Every request gives exactly one result; wait for the last of them,
        // then let the clock run on to catch any stray result.
        while (shadow.awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (shadow.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/plstore_pkg.sv
sv/plstore_stream_if.sv
sv/plstore_cell.sv
sv/positional_list_store_core.sv
sv/plstore_checker.sv
dv/tb.sv
